@@ rtl/apt_pkg.sv @@
// apt_pkg: shared types and constants for the affine point transform
// covers q16.16 field widths, matrix register indexes and pipeline controls
// no dependencies
package apt_pkg;

   // q16.16 field and register geometry
   localparam int unsigned COORD_W   = 32;
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned PROD_W    = 2 * COORD_W;
   localparam int unsigned ACC_W     = PROD_W + 2;
   localparam int unsigned REG_W     = 64;
   localparam int unsigned NUM_REGS  = 6;
   localparam int unsigned IDX_W     = 3;
   localparam int unsigned NUM_ROWS  = 3;
   localparam int unsigned BEAT_W    = NUM_ROWS * COORD_W;

   // register indexes on the csr channel
   localparam logic [IDX_W-1:0] REG_ROW0_FIRST  = 3'd0;
   localparam logic [IDX_W-1:0] REG_ROW0_SECOND = 3'd1;
   localparam logic [IDX_W-1:0] REG_ROW1_FIRST  = 3'd2;
   localparam logic [IDX_W-1:0] REG_ROW1_SECOND = 3'd3;
   localparam logic [IDX_W-1:0] REG_ROW2_FIRST  = 3'd4;
   localparam logic [IDX_W-1:0] REG_ROW2_SECOND = 3'd5;

   // reset values give the identity matrix
   localparam logic [REG_W-1:0] RST_ROW0_FIRST  = 64'h0000_0000_0001_0000;
   localparam logic [REG_W-1:0] RST_ROW0_SECOND = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] RST_ROW1_FIRST  = 64'h0001_0000_0000_0000;
   localparam logic [REG_W-1:0] RST_ROW1_SECOND = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] RST_ROW2_FIRST  = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] RST_ROW2_SECOND = 64'h0000_0000_0001_0000;

   // one half lsb of the q16.16 result, in the q34.32 accumulator
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

   // per-stage load enables shared by all row datapaths
   typedef struct packed {
      logic load_mul;
      logic load_part;
      logic load_total;
      logic load_out;
   } pipe_ctrl_type;

endpackage

@@ rtl/apt_row.sv @@
// apt_row: four-stage datapath for one matrix row (multiply, partial sums,
// total, round and saturate); stage loads come from the top level
// depends on apt_pkg
module apt_row
   import apt_pkg::*;
(
   input  logic                       clock,
   input  pipe_ctrl_type              ctrl,
   input  logic signed [COORD_W-1:0]  point_x,
   input  logic signed [COORD_W-1:0]  point_y,
   input  logic signed [COORD_W-1:0]  point_z,
   input  logic        [REG_W-1:0]    first_pair,
   input  logic        [REG_W-1:0]    second_pair,
   output logic signed [COORD_W-1:0]  result
);

   logic signed [COORD_W-1:0] coef0;
   logic signed [COORD_W-1:0] coef1;
   logic signed [COORD_W-1:0] coef2;
   logic signed [COORD_W-1:0] trans;

   logic signed [PROD_W-1:0] prod0_ff, prod0_in;
   logic signed [PROD_W-1:0] prod1_ff, prod1_in;
   logic signed [PROD_W-1:0] prod2_ff, prod2_in;
   logic        [ACC_W-1:0]  pair_ff, pair_in;
   logic        [ACC_W-1:0]  rest_ff, rest_in;
   logic        [ACC_W-1:0]  total_ff, total_in;
   logic signed [COORD_W-1:0] result_ff, result_in;

   logic [ACC_W-FRAC_W-1:0] shifted;
   logic                    in_range;

   // unpack the row entries
   assign coef0 = first_pair[COORD_W-1:0];
   assign coef1 = first_pair[REG_W-1:COORD_W];
   assign coef2 = second_pair[COORD_W-1:0];
   assign trans = second_pair[REG_W-1:COORD_W];

   // stage 1: full-precision q32.32 products
   assign prod0_in = PROD_W'(coef0 * point_x);
   assign prod1_in = PROD_W'(coef1 * point_y);
   assign prod2_in = PROD_W'(coef2 * point_z);

   // stage 2: two partial sums, translation and rounding half folded in
   assign pair_in = {{2{prod0_ff[PROD_W-1]}}, prod0_ff}
                  + {{2{prod1_ff[PROD_W-1]}}, prod1_ff};
   assign rest_in = {{2{prod2_ff[PROD_W-1]}}, prod2_ff}
                  + {{(ACC_W-COORD_W-FRAC_W){trans[COORD_W-1]}}, trans, FRAC_W'(0)}
                  + ROUND_HALF;

   // stage 3: exact row total
   assign total_in = pair_ff + rest_ff;

   // stage 4: floor at the q16.16 point and saturate
   assign shifted  = total_ff[ACC_W-1:FRAC_W];
   assign in_range = (shifted[ACC_W-FRAC_W-1:COORD_W-1] == '0)
                  || (shifted[ACC_W-FRAC_W-1:COORD_W-1] == '1);

   always_comb begin
      priority if (in_range) begin
         result_in = shifted[COORD_W-1:0];
      end else if (total_ff[ACC_W-1]) begin
         result_in = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         result_in = {1'b0, {(COORD_W-1){1'b1}}};
      end
   end

   // payload registers, loaded as each stage advances
   always_ff @(posedge clock) begin
      if (ctrl.load_mul) begin
         prod0_ff <= prod0_in;
         prod1_ff <= prod1_in;
         prod2_ff <= prod2_in;
      end
      if (ctrl.load_part) begin
         pair_ff <= pair_in;
         rest_ff <= rest_in;
      end
      if (ctrl.load_total) begin
         total_ff <= total_in;
      end
      if (ctrl.load_out) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

@@ rtl/affine_point_transform.sv @@
// affine_point_transform: top level, matrix registers, stage valids, handshakes
// and three apt_row datapaths
// depends on apt_pkg and apt_row
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  req_tdata: point_x, point_y, point_z
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: result_x, result_y, result_z
//   csr      in   csr_valid/csr_ready    csr_index, csr_data (64-bit matrix pair)
//
// one point per cycle while rsp is not stalled; a result is offered once its
// beat has passed the multiply, partial sums, total and round and saturate
// stages in that order.
// reset clears the stage valids and loads the identity matrix.
// a stalled rsp holds the output; bubbles ahead of it still close up, and
// req_tready drops only when every stage is full and rsp is stalled.
// csr_ready is always high; an index past the last register is ignored.
module affine_point_transform
   import apt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // req_tdata: point_x [31:0], point_y [63:32], point_z [95:64]
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [BEAT_W-1:0]   req_tdata,
   // rsp_tdata: result_x [31:0], result_y [63:32], result_z [95:64]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [BEAT_W-1:0]   rsp_tdata,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [IDX_W-1:0]    csr_index,
   input  logic [REG_W-1:0]    csr_data
);

   logic [REG_W-1:0] mat_ff [NUM_REGS];
   logic [3:0]       valid_ff, valid_in;
   logic [3:0]       adv;
   pipe_ctrl_type    ctrl;
   logic signed [COORD_W-1:0] point [NUM_ROWS];
   logic signed [COORD_W-1:0] result [NUM_ROWS];

   assign csr_ready = 1'b1;

   // matrix register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff[REG_ROW0_FIRST]  <= RST_ROW0_FIRST;
         mat_ff[REG_ROW0_SECOND] <= RST_ROW0_SECOND;
         mat_ff[REG_ROW1_FIRST]  <= RST_ROW1_FIRST;
         mat_ff[REG_ROW1_SECOND] <= RST_ROW1_SECOND;
         mat_ff[REG_ROW2_FIRST]  <= RST_ROW2_FIRST;
         mat_ff[REG_ROW2_SECOND] <= RST_ROW2_SECOND;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ROW0_FIRST:  mat_ff[REG_ROW0_FIRST]  <= csr_data;
            REG_ROW0_SECOND: mat_ff[REG_ROW0_SECOND] <= csr_data;
            REG_ROW1_FIRST:  mat_ff[REG_ROW1_FIRST]  <= csr_data;
            REG_ROW1_SECOND: mat_ff[REG_ROW1_SECOND] <= csr_data;
            REG_ROW2_FIRST:  mat_ff[REG_ROW2_FIRST]  <= csr_data;
            REG_ROW2_SECOND: mat_ff[REG_ROW2_SECOND] <= csr_data;
            default: ;
         endcase
      end
   end

   // stage advance: a stage loads when it is empty or its content moves on
   assign adv[3] = !valid_ff[3] || rsp_tready;
   assign adv[2] = !valid_ff[2] || adv[3];
   assign adv[1] = !valid_ff[1] || adv[2];
   assign adv[0] = !valid_ff[0] || adv[1];

   assign req_tready = adv[0];

   assign ctrl.load_mul   = adv[0];
   assign ctrl.load_part  = adv[1];
   assign ctrl.load_total = adv[2];
   assign ctrl.load_out   = adv[3];

   // valid bits travel with the data
   always_comb begin
      valid_in[0] = adv[0] ? req_tvalid  : valid_ff[0];
      valid_in[1] = adv[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = adv[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = adv[3] ? valid_ff[2] : valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // unpack the input beat
   assign point[0] = req_tdata[COORD_W-1:0];
   assign point[1] = req_tdata[2*COORD_W-1:COORD_W];
   assign point[2] = req_tdata[3*COORD_W-1:2*COORD_W];

   // one datapath per matrix row
   for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
      apt_row u_row (
         .clock       (clock),
         .ctrl        (ctrl),
         .point_x     (point[0]),
         .point_y     (point[1]),
         .point_z     (point[2]),
         .first_pair  (mat_ff[2*r]),
         .second_pair (mat_ff[2*r+1]),
         .result      (result[r])
      );
   end

   // output beat
   assign rsp_tvalid = valid_ff[3];
   assign rsp_tdata  = {result[2], result[1], result[0]};

endmodule
